/* design/dce_pkg.sv */
package dce_pkg;

  localparam int MAX_ROWS_DEF = 1024;
  localparam int VALUE_W      = 32;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = 2 * VALUE_W;
  localparam int DIFF_W       = PROD_W - FRAC_W + 1;
  localparam int INDEX_W      = 10;
  localparam int ROWS_W       = 11;
  localparam int EPOCH_W      = 6;

  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1024);
  localparam logic signed [VALUE_W-1:0] ONE_Q = VALUE_W'(1) << FRAC_W;

  // operation codes
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_BEGIN = 3'd1;
  localparam logic [2:0] OP_ENTRY = 3'd2;
  localparam logic [2:0] OP_END   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_DIAG  = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } store_req_t;

  typedef struct packed {
    logic                      fixed;
    logic signed [VALUE_W-1:0] value;
  } store_rsp_t;

  typedef struct packed {
    logic [2:0]                op;
    logic                      in_range;
    logic                      diag;
    logic signed [VALUE_W-1:0] value;
  } item_t;

endpackage

/* design/dirichlet_csr_elimination.sv */
// Dirichlet row/column elimination over a CSR matrix stream, Q16.16 values.
// Item channel (operation, index, value; item_valid / item_stall) carries
// loads of fixed indices, row begin, matrix entry, row end and clear items.
// Result channel (result_value, status; result_valid / result_stall) gives
// one beat for each load, entry and end item, and for an out-of-range begin.
// Items pass the accept stage (it1, memory lookup), the product stage
// (it2, prod2) and the registered result stage; stalls can hold each.
// Throughput: one item per cycle while item_stall is low; the fixed-flag/value
// memory lookup at accept and the registered multiply and saturating subtract
// keep up with it, since the accumulator is updated within the last stage.
// A clear bumps the flag epoch; every 64th clear wraps it and starts a
// sweep over all MAX_ROWS flag entries with items stalled.
// Reset starts the same sweep, so item_stall stays high after rst falls
// until the sweep ends; cfg writes are taken at any time.
// When the receiver stalls, the held result beat stays put and the pipe
// keeps taking items until its stages fill; item_stall then rises.
module dirichlet_csr_elimination #(
  parameter int MAX_ROWS = dce_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dce_pkg::ROWS_W-1:0]          cfg_wdata,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [2:0]                          operation,
  input  logic [dce_pkg::INDEX_W-1:0]         index,
  input  logic signed [dce_pkg::VALUE_W-1:0]  value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [dce_pkg::VALUE_W-1:0]  result_value,
  output logic [1:0]                          status
);

  localparam int AW = $clog2(MAX_ROWS);

  logic [dce_pkg::ROWS_W-1:0]  rows_in_use;
  logic [dce_pkg::INDEX_W-1:0] cur_row;

  logic                        accept;
  logic                        in_range;
  logic                        to_pipe;
  logic                        pipe_ready;
  logic                        busy;
  logic [AW-1:0]               addr;

  dce_pkg::store_req_t         req;
  dce_pkg::store_rsp_t         rsp;
  dce_pkg::item_t              item;

  // the row-count register
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= dce_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      rows_in_use <= cfg_wdata;
    end
  end

  // hold items off during a flag sweep or when the first stage cannot move
  assign item_stall = busy || !pipe_ready;
  assign accept     = item_valid && !item_stall;

  assign in_range = ({1'b0, index} < rows_in_use) && (32'(index) < 32'(MAX_ROWS));

  // clears only touch the epoch and unused codes do nothing, so both skip the pipe
  assign to_pipe = accept && ((operation == dce_pkg::OP_LOAD) ||
                              (operation == dce_pkg::OP_BEGIN) ||
                              (operation == dce_pkg::OP_ENTRY) ||
                              (operation == dce_pkg::OP_END));

  // track the open row at the front so an end right after a begin reads
  // the new row's fixed value
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
    end else if (accept && (operation == dce_pkg::OP_BEGIN)) begin
      cur_row <= index;
    end
  end

  assign addr = (operation == dce_pkg::OP_END) ? AW'(cur_row) : AW'(index);

  // loads write at accept; lookups read at accept, so later items see them
  assign req.rd    = accept;
  assign req.wr    = accept && (operation == dce_pkg::OP_LOAD) && in_range;
  assign req.clear = accept && (operation == dce_pkg::OP_CLEAR);

  assign item.op       = operation;
  assign item.in_range = in_range;
  assign item.diag     = (index == cur_row);
  assign item.value    = value;

  dce_store #(
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .addr     (addr),
    .wr_value (value),
    .rsp      (rsp),
    .busy     (busy)
  );

  dce_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .push         (to_pipe),
    .item         (item),
    .rsp          (rsp),
    .result_stall (result_stall),
    .ready        (pipe_ready),
    .result_valid (result_valid),
    .result_value (result_value),
    .status       (status)
  );

endmodule

/* design/dce_store.sv */
module dce_store #(
  parameter int MAX_ROWS = dce_pkg::MAX_ROWS_DEF,
  localparam int AW = $clog2(MAX_ROWS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dce_pkg::store_req_t               req,
  input  logic [AW-1:0]                     addr,
  input  logic signed [dce_pkg::VALUE_W-1:0] wr_value,
  output dce_pkg::store_rsp_t               rsp,
  output logic                              busy
);

  localparam logic [AW-1:0] LAST = AW'(MAX_ROWS - 1);

  // flag entry: {set, epoch at write}
  logic [dce_pkg::EPOCH_W:0]         flag_mem [MAX_ROWS];
  logic [dce_pkg::VALUE_W-1:0]       value_mem [MAX_ROWS];
  logic [dce_pkg::EPOCH_W:0]         flag_rd;
  logic [dce_pkg::VALUE_W-1:0]       value_rd;
  logic [dce_pkg::EPOCH_W-1:0]       epoch;
  logic [AW-1:0]                     clr_addr;

  always_ff @(posedge clk) begin
    if (busy) begin
      flag_mem[clr_addr] <= '0;
    end else if (req.wr) begin
      flag_mem[addr] <= {1'b1, epoch};
    end
    if (req.rd) begin
      flag_rd <= flag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      value_mem[addr] <= wr_value;
    end
    if (req.rd) begin
      value_rd <= value_mem[addr];
    end
  end

  // epoch advances on clear; sweep the flags when it wraps and after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      epoch    <= '0;
    end else if (busy) begin
      if (clr_addr == LAST) begin
        busy     <= 1'b0;
        clr_addr <= '0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end else if (req.clear) begin
      epoch <= epoch + dce_pkg::EPOCH_W'(1);
      if (&epoch) begin
        busy     <= 1'b1;
        clr_addr <= '0;
      end
    end
  end

  assign rsp.fixed = flag_rd[dce_pkg::EPOCH_W] &&
                     (flag_rd[dce_pkg::EPOCH_W-1:0] == epoch);
  assign rsp.value = value_rd;

endmodule

/* design/dce_pipe.sv */
module dce_pipe (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  dce_pkg::item_t                     item,
  input  dce_pkg::store_rsp_t                rsp,
  input  logic                               result_stall,
  output logic                               ready,
  output logic                               result_valid,
  output logic signed [dce_pkg::VALUE_W-1:0] result_value,
  output logic [1:0]                         status
);

  localparam int VW = dce_pkg::VALUE_W;
  localparam int DW = dce_pkg::DIFF_W;

  logic                       v1;
  dce_pkg::item_t             it1;

  logic                       v2;
  dce_pkg::item_t             it2;
  logic                       fix2;
  logic signed [VW-1:0]       fv2;
  logic signed [dce_pkg::PROD_W-1:0] prod2;
  logic signed [dce_pkg::PROD_W-1:0] prod;

  logic                       en1;
  logic                       en2;

  // row state
  logic signed [VW-1:0]       acc;
  logic                       row_fixed;
  logic                       diag_seen;
  logic                       sat_seen;
  logic                       row_bad;

  logic signed [VW-1:0]       acc_next;
  logic                       row_fixed_next;
  logic                       diag_seen_next;
  logic                       sat_seen_next;
  logic                       row_bad_next;
  logic                       has_res;
  logic signed [VW-1:0]       res_val;
  logic [1:0]                 res_st;

  logic signed [DW-1:0]       diff;
  logic                       fits;
  logic signed [VW-1:0]       diff_sat;

  assign en2   = v2 && (!result_valid || !result_stall);
  assign en1   = v1 && (!v2 || en2);
  assign ready = !v1 || en1;

  assign prod = it1.value * rsp.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (push) begin
        v1 <= 1'b1;
      end else if (en1) begin
        v1 <= 1'b0;
      end
      if (en1) begin
        v2 <= 1'b1;
      end else if (en2) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      it1 <= item;
    end
    if (en1) begin
      it2   <= it1;
      fix2  <= rsp.fixed;
      fv2   <= rsp.value;
      prod2 <= prod;
    end
  end

  // floor of product in Q16.16 is an arithmetic shift
  assign diff = DW'(acc) - DW'(prod2 >>> dce_pkg::FRAC_W);
  assign fits = (&diff[DW-1:VW-1]) || !(|diff[DW-1:VW-1]);

  always_comb begin
    if (fits) begin
      diff_sat = diff[VW-1:0];
    end else if (diff[DW-1]) begin
      diff_sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      diff_sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_comb begin
    acc_next       = acc;
    row_fixed_next = row_fixed;
    diag_seen_next = diag_seen;
    sat_seen_next  = sat_seen;
    row_bad_next   = row_bad;
    has_res        = 1'b0;
    res_val        = '0;
    res_st         = dce_pkg::ST_OK;
    unique case (it2.op)
      dce_pkg::OP_LOAD: begin
        has_res = 1'b1;
        res_st  = it2.in_range ? dce_pkg::ST_OK : dce_pkg::ST_RANGE;
      end
      dce_pkg::OP_BEGIN: begin
        acc_next       = it2.value;
        row_fixed_next = it2.in_range && fix2;
        diag_seen_next = 1'b0;
        sat_seen_next  = 1'b0;
        row_bad_next   = !it2.in_range;
        has_res        = !it2.in_range;
        res_st         = dce_pkg::ST_RANGE;
      end
      dce_pkg::OP_ENTRY: begin
        has_res = 1'b1;
        if (!it2.in_range) begin
          res_val = it2.value;
          res_st  = dce_pkg::ST_RANGE;
        end else if (row_fixed) begin
          if (it2.diag) begin
            diag_seen_next = 1'b1;
            res_val        = dce_pkg::ONE_Q;
          end
        end else if (fix2) begin
          acc_next = diff_sat;
          if (!fits) begin
            sat_seen_next = 1'b1;
            res_st        = dce_pkg::ST_SAT;
          end
        end else begin
          res_val = it2.value;
        end
      end
      dce_pkg::OP_END: begin
        has_res = 1'b1;
        if (row_bad) begin
          res_val = acc;
          res_st  = dce_pkg::ST_RANGE;
        end else if (row_fixed) begin
          res_val = fv2;
          res_st  = diag_seen ? dce_pkg::ST_OK : dce_pkg::ST_NO_DIAG;
        end else begin
          res_val = acc;
          res_st  = sat_seen ? dce_pkg::ST_SAT : dce_pkg::ST_OK;
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      row_fixed    <= 1'b0;
      diag_seen    <= 1'b0;
      sat_seen     <= 1'b0;
      row_bad      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en2) begin
        acc          <= acc_next;
        row_fixed    <= row_fixed_next;
        diag_seen    <= diag_seen_next;
        sat_seen     <= sat_seen_next;
        row_bad      <= row_bad_next;
        result_valid <= has_res;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && has_res) begin
      result_value <= res_val;
      status       <= res_st;
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;

  localparam int VALUE_W      = dce_pkg::VALUE_W;
  localparam int INDEX_W      = dce_pkg::INDEX_W;
  localparam int ROWS_W       = dce_pkg::ROWS_W;
  localparam int FRAC_W       = dce_pkg::FRAC_W;
  localparam int MAX_ROWS_DEF = dce_pkg::MAX_ROWS_DEF;

  // Stop the run once this many cycles pass with no beat on either channel.
  // The worst legitimate quiet stretch is a flag sweep over all MAX_ROWS
  // entries stacked on the long receiver hold-off, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 20000;
  // Cycles to let pass once nothing is awaited.
  localparam int SETTLE = 8;

  // Operation codes the block must ignore.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic [1:0]                stat;
  } beat_t;

  // One row of the opening sequence. When typed is set, rval/rstat give the
  // result beat directly; otherwise the elimination predictor supplies it.
  typedef struct packed {
    logic [2:0]         op;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic               typed;
    logic [VALUE_W-1:0] rval;
    logic [1:0]         rstat;
  } step_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [ROWS_W-1:0]         cfg_wdata;
  logic                      item_valid;
  logic                      item_stall;
  logic [2:0]                operation;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic                      result_valid;
  logic                      result_stall;
  logic signed [VALUE_W-1:0] result_value;
  logic [1:0]                status;

  // Predictor state: fixed flags and values, the open row, the right-hand
  // accumulator and the sticky per-row flags.
  logic [ROWS_W-1:0]         rows_cfg = dce_pkg::ROWS_RESET;
  bit                        is_fixed [MAX_ROWS_DEF];
  logic signed [VALUE_W-1:0] pinned_value [MAX_ROWS_DEF];
  logic [INDEX_W-1:0]        row_sel = '0;
  bit                        row_pinned = 1'b0;
  logic signed [VALUE_W-1:0] rhs_acc = '0;
  bit                        diag_hit = 1'b0;
  bit                        sat_hit = 1'b0;
  bit                        row_oob = 1'b0;

  beat_t awaited_results [$];

  int items_taken = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Opening sequence, run with rows_in_use = 16 so that index 16 and up is
  // out of range.
  step_t warmup_steps [27] = '{
    // entry and end before any begin: use the row state left by reset
    '{dce_pkg::OP_ENTRY, 10'd3,    32'h0001_2345, 1'b1, 32'h0001_2345, dce_pkg::ST_OK},
    '{dce_pkg::OP_END,   10'd0,    32'h0000_0000, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    // loads: out of range, top index, then valid ones (index 5 twice)
    '{dce_pkg::OP_LOAD,  10'd20,   32'h0000_1234, 1'b1, 32'h0000_0000, dce_pkg::ST_RANGE},
    '{dce_pkg::OP_LOAD,  10'd1023, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, dce_pkg::ST_RANGE},
    '{dce_pkg::OP_LOAD,  10'd2,    32'h0002_0000, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_LOAD,  10'd5,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_LOAD,  10'd5,    32'h8000_0000, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_LOAD,  10'd0,    32'h0003_0000, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    // fixed row with its diagonal and an out-of-range column
    '{dce_pkg::OP_BEGIN, 10'd2,    32'h0000_1000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd0,    32'h0000_0005, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd2,    32'h0000_0007, 1'b1, dce_pkg::ONE_Q, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd40,   32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFD, dce_pkg::ST_RANGE},
    '{dce_pkg::OP_END,   10'd0,    32'h0000_0000, 1'b1, 32'h0002_0000, dce_pkg::ST_OK},
    // fixed row without a diagonal
    '{dce_pkg::OP_BEGIN, 10'd0,    32'h0000_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd1,    32'h0000_0009, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_END,   10'd0,    32'h0000_0000, 1'b1, 32'h0003_0000, dce_pkg::ST_NO_DIAG},
    // free row: elimination, a load mid-row, floor rounding, saturation
    '{dce_pkg::OP_BEGIN, 10'd1,    32'h0000_1000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd2,    32'h0001_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_LOAD,  10'd3,    32'h0001_8000, 1'b1, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd3,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_ENTRY, 10'd5,    32'h8000_0000, 1'b1, 32'h0000_0000, dce_pkg::ST_SAT},
    '{dce_pkg::OP_END,   10'd0,    32'h0000_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    // out-of-range row still accumulates, end reports the range error
    '{dce_pkg::OP_BEGIN, 10'd16,   32'h0000_1234, 1'b1, 32'h0000_0000, dce_pkg::ST_RANGE},
    '{dce_pkg::OP_ENTRY, 10'd2,    32'h0001_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_END,   10'd0,    32'h0000_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    // ignored code, then clear the flags
    '{OP_RSVD7,          10'd1023, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, dce_pkg::ST_OK},
    '{dce_pkg::OP_CLEAR, 10'd0,    32'h0000_0000, 1'b0, 32'h0000_0000, dce_pkg::ST_OK}
  };

  dirichlet_csr_elimination dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .index        (index),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predictor by one accepted item. Returns 1 when the item
  // produces a result beat, with that beat in r.
  function automatic bit apply_elimination(input logic [2:0] op,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic signed [VALUE_W-1:0] val,
                                           output beat_t r);
    int unsigned lim;
    bit ok;
    longint prod;
    longint diff;
    lim = (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_cfg;
    ok = idx < lim;
    r = '0;
    apply_elimination = 1'b1;
    case (op)
      dce_pkg::OP_LOAD: begin
        if (!ok) begin
          r.stat = dce_pkg::ST_RANGE;
        end else begin
          is_fixed[idx] = 1'b1;
          pinned_value[idx] = val;
        end
      end
      dce_pkg::OP_BEGIN: begin
        // Row fixedness is latched here; later loads do not change it.
        row_sel = idx;
        row_pinned = ok && is_fixed[idx];
        rhs_acc = val;
        diag_hit = 1'b0;
        sat_hit = 1'b0;
        row_oob = !ok;
        if (ok) apply_elimination = 1'b0;
        else r.stat = dce_pkg::ST_RANGE;
      end
      dce_pkg::OP_ENTRY: begin
        if (!ok) begin
          r.val = val;
          r.stat = dce_pkg::ST_RANGE;
        end else if (row_pinned) begin
          if (idx == row_sel) begin
            diag_hit = 1'b1;
            r.val = dce_pkg::ONE_Q;
          end
        end else if (is_fixed[idx]) begin
          // Exact Q32.32 product, floor to Q16.16, saturating subtract.
          prod = longint'(val) * longint'(pinned_value[idx]);
          diff = longint'(rhs_acc) - (prod >>> FRAC_W);
          if (diff > SUM_MAX || diff < SUM_MIN) begin
            diff = (diff > SUM_MAX) ? SUM_MAX : SUM_MIN;
            sat_hit = 1'b1;
            r.stat = dce_pkg::ST_SAT;
          end
          rhs_acc = diff[VALUE_W-1:0];
        end else begin
          r.val = val;
        end
      end
      dce_pkg::OP_END: begin
        // Status priority: range, then missing diagonal, then saturation.
        if (row_oob) begin
          r.val = rhs_acc;
          r.stat = dce_pkg::ST_RANGE;
        end else if (row_pinned) begin
          r.val = pinned_value[row_sel];
          r.stat = diag_hit ? dce_pkg::ST_OK : dce_pkg::ST_NO_DIAG;
        end else begin
          r.val = rhs_acc;
          r.stat = sat_hit ? dce_pkg::ST_SAT : dce_pkg::ST_OK;
        end
      end
      dce_pkg::OP_CLEAR: begin
        foreach (is_fixed[i]) is_fixed[i] = 1'b0;
        apply_elimination = 1'b0;
      end
      default: apply_elimination = 1'b0;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still
  // high, so the next beat can follow without a bubble.
  task automatic drive_beat(input logic [2:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val, input bit typed = 1'b0,
                            input logic [VALUE_W-1:0] tval = '0,
                            input logic [1:0] tstat = dce_pkg::ST_OK);
    beat_t r;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      operation <= 3'($urandom);
      index <= INDEX_W'($urandom);
      value <= $urandom;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    index <= idx;
    value <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (apply_elimination(op, idx, val, r)) begin
      if (typed) begin
        r.val = tval;
        r.stat = tstat;
      end
      awaited_results = {awaited_results, r};
    end
    if (op < OP_RSVD5) items_taken++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every awaited beat, then cover items that give no
  // result (begin, clear) still in flight.
  task automatic let_pipe_empty();
    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_rows(input logic [ROWS_W-1:0] n);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    rows_cfg = n;
  endtask

  // Mostly in range and crowded into the low indices, so loads and rows hit
  // each other often; some picks span the full 10-bit field.
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(99);
    if (lim == 0 || r < 10) return INDEX_W'($urandom);
    if (r < 70) return INDEX_W'($urandom_range(((lim < 16) ? lim : 16) - 1));
    return INDEX_W'($urandom_range(lim - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      4: return '0;
      default: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  // One phase of random traffic: mostly well-formed rows with load bursts in
  // between, plus clears, ignored codes and stray entries or ends.
  task automatic run_phase(input logic [ROWS_W-1:0] rows, input int sidle,
                           input int rstall, input int n, input int hold,
                           input bit pause_mid);
    int unsigned lim;
    int start;
    int r;
    bit paused;
    logic [INDEX_W-1:0] row;
    let_pipe_empty();
    write_rows(rows);
    lim = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
    idle_pct = sidle;
    stall_pct = rstall;
    hold_left = hold;
    start = items_taken;
    paused = 1'b0;
    while (items_taken - start < n) begin
      if (pause_mid && !paused && items_taken - start >= n / 2) begin
        let_pipe_empty();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 3) begin
        drive_beat(dce_pkg::OP_CLEAR, INDEX_W'($urandom), $urandom);
      end else if (r < 7) begin
        case ($urandom_range(2))
          0: drive_beat(OP_RSVD5, INDEX_W'($urandom), $urandom);
          1: drive_beat(OP_RSVD6, INDEX_W'($urandom), $urandom);
          default: drive_beat(OP_RSVD7, INDEX_W'($urandom), $urandom);
        endcase
        if ($urandom_range(1)) drive_beat(dce_pkg::OP_ENTRY, pick_index(lim), rand_value());
        else drive_beat(dce_pkg::OP_END, INDEX_W'($urandom), $urandom);
      end else if (r < 27) begin
        repeat ($urandom_range(4, 1))
          drive_beat(dce_pkg::OP_LOAD, pick_index(lim), rand_value());
      end else begin
        row = pick_index(lim);
        drive_beat(dce_pkg::OP_BEGIN, row, rand_value());
        repeat ($urandom_range(6)) begin
          if ($urandom_range(99) < 8)
            drive_beat(dce_pkg::OP_LOAD, pick_index(lim), rand_value());
          drive_beat(dce_pkg::OP_ENTRY, ($urandom_range(99) < 25) ? row : pick_index(lim),
                     rand_value());
        end
        // Now and then leave the row open; the next begin replaces it.
        if ($urandom_range(99) < 95) drive_beat(dce_pkg::OP_END, INDEX_W'($urandom), $urandom);
      end
    end
  endtask

  // Receiver: a requested hold-off is counted down here; otherwise stall at
  // the phase's rate.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check each result beat against the oldest awaited one.
  always @(posedge clk) begin : check_results
    beat_t e;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: result_value %h status %0d", result_value, status);
        fail_count++;
      end else begin
        e = awaited_results.pop_front();
        if (result_value !== e.val) begin
          $error("result_value: expected %h, got %h", e.val, result_value);
          fail_count++;
        end
        if (status !== e.stat) begin
          $error("status: expected %0d, got %0d", e.stat, status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_valid = 1'b0;
    operation = dce_pkg::OP_LOAD;
    index = '0;
    value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening sequence with a small row count; the flag sweep after reset
    // holds the first beat off until it finishes.
    write_rows(ROWS_W'(16));
    foreach (warmup_steps[i])
      drive_beat(warmup_steps[i].op, warmup_steps[i].idx, warmup_steps[i].val,
                 warmup_steps[i].typed, warmup_steps[i].rval, warmup_steps[i].rstat);

    // Random phases: row counts span zero, one, the full store and the
    // 11-bit maximum. The first phase holds the receiver off for a long
    // stretch while items keep coming, so the pipe fills and stalls input;
    // two phases pause the sender midway until nothing is awaited.
    run_phase(ROWS_W'(1024), 0, 0, 230, 400, 1'b0);
    run_phase(ROWS_W'(2047), 79, 0, 175, 0, 1'b0);
    run_phase(ROWS_W'(40), 0, 79, 175, 0, 1'b1);
    run_phase(ROWS_W'(1), 22, 22, 175, 0, 1'b0);
    run_phase(ROWS_W'(0), 0, 0, 100, 0, 1'b0);
    run_phase(ROWS_W'($urandom_range(1024, 2)), 22, 22, 175, 0, 1'b0);
    run_phase(ROWS_W'(300), 0, 79, 175, 0, 1'b0);
    run_phase(ROWS_W'(1024), 22, 22, 175, 0, 1'b1);
    let_pipe_empty();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
design/dce_pkg.sv
design/dce_store.sv
design/dce_pipe.sv
design/dirichlet_csr_elimination.sv
tb/tb_top.sv
